// ----- hw/rtl/rti_pkg.sv -----
// Package for the ray/triangle intersection block: widths, payload types,
// status structs and component unpacking. No dependencies.
`default_nettype none

package rti_pkg;

    localparam int CW   = 21;          // bits per packed vector component
    localparam int IW   = 63;          // width of a packed input vector
    localparam int EW   = CW + 1;      // edges and origin offset
    localparam int PW   = 2 * EW;      // cross product terms
    localparam int XW   = PW + 1;      // cross product components
    localparam int DPW  = EW + XW;     // dot product terms
    localparam int DW   = DPW + 2;     // dot products
    localparam int SW   = DW + 2;      // signed bounds compares
    localparam int FRAC = 16;          // fraction bits of the quotients
    localparam int TW   = DW + FRAC;   // distance overflow compare
    localparam int QTW  = 32;          // distance quotient bits
    localparam int UQW  = 17;          // barycentric quotient bits
    localparam int RW   = DW + QTW;    // divider remainders
    localparam int NS   = QTW;         // divider stages
    localparam int MQD  = 4;           // middle queue depth
    localparam int MQAW = $clog2(MQD);

    localparam logic [QTW-1:0] DIST_MAX = {1'b0, {(QTW-1){1'b1}}};
    localparam logic [QTW-1:0] DIST_MIN = {1'b1, {(QTW-1){1'b0}}};

    typedef logic signed [EW-1:0] ecomp_t;
    typedef logic signed [XW-1:0] xcomp_t;

    typedef struct packed {
        ecomp_t z;
        ecomp_t y;
        ecomp_t x;
    } evec_t;

    typedef struct packed {
        xcomp_t z;
        xcomp_t y;
        xcomp_t x;
    } xvec_t;

    // classified item handed from front to back
    typedef struct packed {
        logic          hit;
        logic          tneg;
        logic          tsat;
        logic [DW-1:0] det;
        logic [DW-1:0] un;
        logic [DW-1:0] vn;
        logic [DW-1:0] tmag;
    } mid_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic           hit;
        logic [QTW-1:0] distance;
        logic [UQW-1:0] u;
        logic [UQW-1:0] v;
    } res_t;

    function automatic evec_t unpack(input logic [IW-1:0] w);
        evec_t r;
        r.x = ecomp_t'(signed'(w[0 +: CW]));
        r.y = ecomp_t'(signed'(w[CW +: CW]));
        r.z = ecomp_t'(signed'(w[2*CW +: CW]));
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ray_triangle_intersect_top.sv -----
// Top level of the ray/triangle intersection block: epsilon register,
// front end, middle queue and back end. Depends on rti_pkg and submodules.
//
//   channel   direction  handshake             payload
//   input     in         push / full           ray_origin .. corner_c
//   result    out        empty / pop           hit distance bary_u bary_v
//   config    in         cfg_we                cfg_wdata (det_epsilon)
//
// One item enters per cycle and one result leaves per cycle when neither
// side stalls. An accepted item passes the front stages, the middle queue,
// 32 divider stages (one distance quotient bit per stage, one u and one v
// bit per stage for bits below UQW) and the result queue.
// A stalled result queue holds the divider, which in turn fills the middle
// queue and then raises full. Reset clears all queues and valid bits and
// sets det_epsilon to 68719.
`default_nettype none

module ray_triangle_intersect_top import rti_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [IW-1:0]     ray_origin,
    input  wire logic [IW-1:0]     ray_direction,
    input  wire logic [IW-1:0]     corner_a,
    input  wire logic [IW-1:0]     corner_b,
    input  wire logic [IW-1:0]     corner_c,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   hit,
    output logic signed [31:0]     distance,
    output logic [UQW-1:0]         bary_u,
    output logic [UQW-1:0]         bary_v,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_wdata
);

    localparam logic [31:0] EPS_RESET = 32'd68719;

    logic [31:0] eps_reg;
    q_stat_t     mq_stat;
    logic        mq_push, mq_pop;
    mid_t        mq_wdata, mq_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_wdata;
        end
    end

    rti_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .ray_origin    (ray_origin),
        .ray_direction (ray_direction),
        .corner_a      (corner_a),
        .corner_b      (corner_b),
        .corner_c      (corner_c),
        .eps           (eps_reg),
        .mq_stat       (mq_stat),
        .mq_push       (mq_push),
        .mq_data       (mq_wdata)
    );

    rti_midq u_midq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mq_push),
        .wdata (mq_wdata),
        .pop   (mq_pop),
        .stat  (mq_stat),
        .rdata (mq_rdata)
    );

    rti_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .mq_data  (mq_rdata),
        .mq_stat  (mq_stat),
        .mq_pop   (mq_pop),
        .pop      (pop),
        .empty    (empty),
        .hit      (hit),
        .distance (distance),
        .bary_u   (bary_u),
        .bary_v   (bary_v)
    );

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !hit) |-> (distance == 32'sd0 && bary_u == '0 && bary_v == '0))
        else $error("miss result carries non-zero fields");

    a_bary_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && hit) |-> (({1'b0, bary_u} + {1'b0, bary_v}) <= 18'd65536))
        else $error("barycentric u + v exceeds one");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(hit) && $stable(distance)
                              && $stable(bary_u) && $stable(bary_v)))
        else $error("waiting result changed");

endmodule

`default_nettype wire

// ----- hw/rtl/rti_front.sv -----
// Front end: accepts ray/triangle items, forms the dot products and
// classifies hit or miss. Depends on rti_pkg.
`default_nettype none

module rti_front import rti_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [IW-1:0] ray_origin,
    input  wire logic [IW-1:0] ray_direction,
    input  wire logic [IW-1:0] corner_a,
    input  wire logic [IW-1:0] corner_b,
    input  wire logic [IW-1:0] corner_c,
    input  wire logic [31:0]   eps,
    input  wire q_stat_t       mq_stat,
    output logic               mq_push,
    output mid_t               mq_data
);

    localparam int NF = 7;

    logic [NF-1:0] v_reg;
    logic          f_adv;

    evec_t e1_1_reg, e2_1_reg, tv_1_reg, d_1_reg;
    evec_t e1_2_reg, e2_2_reg, tv_2_reg, d_2_reg;
    evec_t e1_3_reg, e2_3_reg, tv_3_reg, d_3_reg;
    logic signed [PW-1:0]  xp_reg [12];
    xvec_t pv_reg, qv_reg;
    logic signed [DPW-1:0] dp_reg [12];
    logic signed [DW-1:0]  det5_reg, un5_reg, vn5_reg, tn5_reg;
    logic [DW-1:0]         det6_reg, tmag6_reg;
    logic signed [DW-1:0]  un6_reg, vn6_reg;
    logic                  tneg6_reg;
    mid_t                  m7_reg;

    evec_t a_in, b_in, c_in, o_in;
    logic  dneg;
    logic signed [SW-1:0] sd, su, sv;
    logic  miss_det, miss_u, miss_v, tsat;

    // advance the whole front unless the last item cannot leave
    assign f_adv   = !v_reg[NF-1] || !mq_stat.full;
    assign full    = !f_adv;
    assign mq_push = v_reg[NF-1] && !mq_stat.full;
    assign mq_data = m7_reg;

    assign a_in = unpack(corner_a);
    assign b_in = unpack(corner_b);
    assign c_in = unpack(corner_c);
    assign o_in = unpack(ray_origin);
    assign dneg = det5_reg[DW-1];

    always_comb
    begin
        sd       = SW'(signed'({1'b0, det6_reg}));
        su       = SW'(un6_reg);
        sv       = SW'(vn6_reg);
        miss_det = (det6_reg == '0) || (det6_reg < DW'(eps));
        miss_u   = (su < 0) || (su > sd);
        miss_v   = (sv < 0) || ((su + sv) > sd);
        tsat     = TW'(tmag6_reg) >= (TW'(det6_reg) << FRAC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (f_adv)
        begin
            v_reg <= {v_reg[NF-2:0], push};
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            e1_1_reg.x <= b_in.x - a_in.x;
            e1_1_reg.y <= b_in.y - a_in.y;
            e1_1_reg.z <= b_in.z - a_in.z;
            e2_1_reg.x <= c_in.x - a_in.x;
            e2_1_reg.y <= c_in.y - a_in.y;
            e2_1_reg.z <= c_in.z - a_in.z;
            tv_1_reg.x <= o_in.x - a_in.x;
            tv_1_reg.y <= o_in.y - a_in.y;
            tv_1_reg.z <= o_in.z - a_in.z;
            d_1_reg    <= unpack(ray_direction);

            // cross product terms: pvec = dir x edge2, qvec = tvec x edge1
            xp_reg[0]  <= PW'(d_1_reg.y) * PW'(e2_1_reg.z);
            xp_reg[1]  <= PW'(d_1_reg.z) * PW'(e2_1_reg.y);
            xp_reg[2]  <= PW'(d_1_reg.z) * PW'(e2_1_reg.x);
            xp_reg[3]  <= PW'(d_1_reg.x) * PW'(e2_1_reg.z);
            xp_reg[4]  <= PW'(d_1_reg.x) * PW'(e2_1_reg.y);
            xp_reg[5]  <= PW'(d_1_reg.y) * PW'(e2_1_reg.x);
            xp_reg[6]  <= PW'(tv_1_reg.y) * PW'(e1_1_reg.z);
            xp_reg[7]  <= PW'(tv_1_reg.z) * PW'(e1_1_reg.y);
            xp_reg[8]  <= PW'(tv_1_reg.z) * PW'(e1_1_reg.x);
            xp_reg[9]  <= PW'(tv_1_reg.x) * PW'(e1_1_reg.z);
            xp_reg[10] <= PW'(tv_1_reg.x) * PW'(e1_1_reg.y);
            xp_reg[11] <= PW'(tv_1_reg.y) * PW'(e1_1_reg.x);
            e1_2_reg   <= e1_1_reg;
            e2_2_reg   <= e2_1_reg;
            tv_2_reg   <= tv_1_reg;
            d_2_reg    <= d_1_reg;

            pv_reg.x   <= XW'(xp_reg[0]) - XW'(xp_reg[1]);
            pv_reg.y   <= XW'(xp_reg[2]) - XW'(xp_reg[3]);
            pv_reg.z   <= XW'(xp_reg[4]) - XW'(xp_reg[5]);
            qv_reg.x   <= XW'(xp_reg[6]) - XW'(xp_reg[7]);
            qv_reg.y   <= XW'(xp_reg[8]) - XW'(xp_reg[9]);
            qv_reg.z   <= XW'(xp_reg[10]) - XW'(xp_reg[11]);
            e1_3_reg   <= e1_2_reg;
            e2_3_reg   <= e2_2_reg;
            tv_3_reg   <= tv_2_reg;
            d_3_reg    <= d_2_reg;

            dp_reg[0]  <= DPW'(e1_3_reg.x) * DPW'(pv_reg.x);
            dp_reg[1]  <= DPW'(e1_3_reg.y) * DPW'(pv_reg.y);
            dp_reg[2]  <= DPW'(e1_3_reg.z) * DPW'(pv_reg.z);
            dp_reg[3]  <= DPW'(tv_3_reg.x) * DPW'(pv_reg.x);
            dp_reg[4]  <= DPW'(tv_3_reg.y) * DPW'(pv_reg.y);
            dp_reg[5]  <= DPW'(tv_3_reg.z) * DPW'(pv_reg.z);
            dp_reg[6]  <= DPW'(d_3_reg.x) * DPW'(qv_reg.x);
            dp_reg[7]  <= DPW'(d_3_reg.y) * DPW'(qv_reg.y);
            dp_reg[8]  <= DPW'(d_3_reg.z) * DPW'(qv_reg.z);
            dp_reg[9]  <= DPW'(e2_3_reg.x) * DPW'(qv_reg.x);
            dp_reg[10] <= DPW'(e2_3_reg.y) * DPW'(qv_reg.y);
            dp_reg[11] <= DPW'(e2_3_reg.z) * DPW'(qv_reg.z);

            det5_reg <= DW'(dp_reg[0]) + DW'(dp_reg[1]) + DW'(dp_reg[2]);
            un5_reg  <= DW'(dp_reg[3]) + DW'(dp_reg[4]) + DW'(dp_reg[5]);
            vn5_reg  <= DW'(dp_reg[6]) + DW'(dp_reg[7]) + DW'(dp_reg[8]);
            tn5_reg  <= DW'(dp_reg[9]) + DW'(dp_reg[10]) + DW'(dp_reg[11]);

            // fold the determinant sign into the numerators
            det6_reg  <= dneg ? DW'(-det5_reg) : DW'(det5_reg);
            un6_reg   <= dneg ? -un5_reg : un5_reg;
            vn6_reg   <= dneg ? -vn5_reg : vn5_reg;
            tmag6_reg <= tn5_reg[DW-1] ? DW'(-tn5_reg) : DW'(tn5_reg);
            tneg6_reg <= tn5_reg[DW-1] ^ dneg;

            m7_reg.hit  <= !(miss_det || miss_u || miss_v);
            m7_reg.tneg <= tneg6_reg;
            m7_reg.tsat <= tsat;
            m7_reg.det  <= det6_reg;
            m7_reg.un   <= DW'(un6_reg);
            m7_reg.vn   <= DW'(vn6_reg);
            m7_reg.tmag <= tmag6_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rti_midq.sv -----
// Short queue between the classifying front and the dividing back.
// Depends on rti_pkg.
`default_nettype none

module rti_midq import rti_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire mid_t wdata,
    input  wire logic pop,
    output q_stat_t   stat,
    output mid_t      rdata
);

    mid_t            mem [MQD];
    logic [MQAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [MQAW:0]   cnt_reg;
    logic            do_push, do_pop;

    assign stat.full  = (cnt_reg == (MQAW+1)'(MQD));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (MQAW+1)'(do_push) - (MQAW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rti_back.sv -----
// Back end: pipelined restoring division of the three numerators, distance
// saturation and a two-entry result queue. Depends on rti_pkg.
`default_nettype none

module rti_back import rti_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mid_t           mq_data,
    input  wire q_stat_t        mq_stat,
    output logic                mq_pop,
    input  wire logic           pop,
    output logic                empty,
    output logic                hit,
    output logic signed [31:0]  distance,
    output logic [UQW-1:0]      bary_u,
    output logic [UQW-1:0]      bary_v
);

    typedef struct packed {
        logic           hit;
        logic           tneg;
        logic           tsat;
        logic [DW-1:0]  d;
        logic [RW-1:0]  rt;
        logic [RW-1:0]  ru;
        logic [RW-1:0]  rv;
        logic [QTW-1:0] qt;
        logic [UQW-1:0] qu;
        logic [UQW-1:0] qv;
    } div_t;

    div_t       st_in  [NS];
    div_t       st_out [NS];
    div_t       st_reg [NS];
    logic [NS-1:0] bv_reg;
    div_t       b_in;
    logic       back_adv;

    res_t       res_reg [2];
    res_t       res_new;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       out_push, out_pop;

    assign back_adv = !bv_reg[NS-1] || (cnt_reg != 2'd2);
    assign mq_pop   = back_adv && !mq_stat.empty;
    assign out_push = bv_reg[NS-1] && back_adv;
    assign out_pop  = pop && (cnt_reg != 2'd0);
    assign empty    = (cnt_reg == 2'd0);

    always_comb
    begin
        b_in      = '0;
        b_in.hit  = mq_data.hit;
        b_in.tneg = mq_data.tneg;
        b_in.tsat = mq_data.tsat;
        b_in.d    = mq_data.det;
        b_in.rt   = RW'(mq_data.tmag) << FRAC;
        b_in.ru   = RW'(mq_data.un) << FRAC;
        b_in.rv   = RW'(mq_data.vn) << FRAC;
    end

    assign st_in[0] = b_in;

    for (genvar s = 0; s < NS; s++)
    begin : g_div
        localparam int K = QTW - 1 - s;
        logic [RW-1:0] dk;

        if (s > 0)
        begin : g_link
            assign st_in[s] = st_reg[s-1];
        end

        assign dk = RW'(st_in[s].d) << K;

        if (K < UQW)
        begin : g_tuv
            always_comb
            begin
                st_out[s] = st_in[s];
                if (st_in[s].rt >= dk)
                begin
                    st_out[s].rt    = st_in[s].rt - dk;
                    st_out[s].qt[K] = 1'b1;
                end
                if (st_in[s].ru >= dk)
                begin
                    st_out[s].ru    = st_in[s].ru - dk;
                    st_out[s].qu[K] = 1'b1;
                end
                if (st_in[s].rv >= dk)
                begin
                    st_out[s].rv    = st_in[s].rv - dk;
                    st_out[s].qv[K] = 1'b1;
                end
            end
        end
        else
        begin : g_t
            always_comb
            begin
                st_out[s] = st_in[s];
                if (st_in[s].rt >= dk)
                begin
                    st_out[s].rt    = st_in[s].rt - dk;
                    st_out[s].qt[K] = 1'b1;
                end
            end
        end
    end

    // saturate the distance and zero a miss
    always_comb
    begin
        res_new.hit = st_reg[NS-1].hit;
        res_new.u   = st_reg[NS-1].qu;
        res_new.v   = st_reg[NS-1].qv;
        if (st_reg[NS-1].tsat)
        begin
            res_new.distance = st_reg[NS-1].tneg ? DIST_MIN : DIST_MAX;
        end
        else if (st_reg[NS-1].tneg)
        begin
            res_new.distance = (st_reg[NS-1].qt > DIST_MIN) ? DIST_MIN
                                                             : -st_reg[NS-1].qt;
        end
        else
        begin
            res_new.distance = (st_reg[NS-1].qt > DIST_MAX) ? DIST_MAX
                                                             : st_reg[NS-1].qt;
        end
        if (!st_reg[NS-1].hit)
        begin
            res_new = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg     <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (back_adv)
            begin
                bv_reg <= {bv_reg[NS-2:0], mq_pop};
            end
            if (out_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(out_push) - 2'(out_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            for (int i = 0; i < NS; i++)
            begin
                st_reg[i] <= st_out[i];
            end
        end
        if (out_push)
        begin
            res_reg[wr_ptr_reg] <= res_new;
        end
    end

    assign hit      = res_reg[rd_ptr_reg].hit;
    assign distance = signed'(res_reg[rd_ptr_reg].distance);
    assign bary_u   = res_reg[rd_ptr_reg].u;
    assign bary_v   = res_reg[rd_ptr_reg].v;

endmodule

`default_nettype wire
